FILE: sv/htbd_pkg.sv
// Shared types and constants for the Huffman tree bit decoder.
// No dependencies; used by htbd_ctrl, htbd_dp and huffman_tree_bit_decoder.
package htbd_pkg;

  localparam int CMD_W    = 2;
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 7;
  localparam int CODE_W   = 64;
  localparam int POS_W    = 6;
  localparam int BITS_W   = 48;
  localparam int STAT_W   = 3;
  localparam int S_DATA_W = 80;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;
  localparam int M_USER_W = 1;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] STAT_INCOMPLETE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SHORT      = 3'd4;
  localparam logic [STAT_W-1:0] STAT_IGNORED    = 3'd5;

  typedef struct packed {
    logic              take;
    logic              clr;
    logic              ld_start;
    logic              rd_node;
    logic              follow;
    logic              link;
    logic              alloc;
    logic              sym_wr;
    logic              dec_start;
    logic              dec_step;
    logic              dec_err;
    logic              dec_leaf;
    logic              dec_down;
    logic              res_set;
    logic              res_valid;
    logic [STAT_W-1:0] res_status;
    logic              out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             err;
    logic             bits_done;
    logic             len_bad;
    logic             len_zero;
    logic             cnt_one;
    logic             slot_zero;
    logic             pool_full;
    logic             leaf;
    logic             cur_root;
    logic             out_free;
  } ctl_stat_t;

endpackage

FILE: sv/htbd_ctrl.sv
// Control state machine for the Huffman tree bit decoder.
// Depends on htbd_pkg; drives htbd_dp through ctl_cmd_t and reads ctl_stat_t.
module htbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  htbd_pkg::ctl_stat_t st,
  output htbd_pkg::ctl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_LRD   = 4'd2;
  localparam logic [3:0] S_LCHK  = 4'd3;
  localparam logic [3:0] S_LNEW  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SWR   = 4'd6;
  localparam logic [3:0] S_DNEXT = 4'd7;
  localparam logic [3:0] S_DEVAL = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.cmd)
          htbd_pkg::CMD_CLEAR: begin
            cmd.clr        = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = htbd_pkg::STAT_OK;
            state_next     = S_RESP;
          end
          htbd_pkg::CMD_LOAD: begin
            if (st.len_bad) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = htbd_pkg::STAT_INVALID;
              state_next     = S_RESP;
            end else begin
              cmd.ld_start = 1'b1;
              state_next   = st.len_zero ? S_SRD : S_LRD;
            end
          end
          htbd_pkg::CMD_DECODE: begin
            if (st.err) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = htbd_pkg::STAT_INVALID;
              state_next     = S_RESP;
            end else if (st.bits_done) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = htbd_pkg::STAT_IGNORED;
              state_next     = S_RESP;
            end else begin
              cmd.dec_start = 1'b1;
              state_next    = S_DNEXT;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            if (st.err) begin
              cmd.res_status = htbd_pkg::STAT_INVALID;
            end else if (!st.bits_done) begin
              cmd.res_status = htbd_pkg::STAT_SHORT;
            end else if (!st.cur_root) begin
              cmd.res_status = htbd_pkg::STAT_INCOMPLETE;
            end else begin
              cmd.res_status = htbd_pkg::STAT_OK;
            end
            state_next = S_RESP;
          end
        endcase
      end
      S_LRD: begin
        cmd.rd_node = 1'b1;
        state_next  = S_LCHK;
      end
      S_LCHK: begin
        if (!st.slot_zero) begin
          cmd.follow = 1'b1;
          state_next = st.cnt_one ? S_SRD : S_LRD;
        end else if (st.pool_full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = htbd_pkg::STAT_FULL;
          state_next     = S_RESP;
        end else begin
          cmd.link   = 1'b1;
          state_next = S_LNEW;
        end
      end
      S_LNEW: begin
        cmd.alloc  = 1'b1;
        state_next = st.cnt_one ? S_SRD : S_LRD;
      end
      S_SRD: begin
        cmd.rd_node = 1'b1;
        state_next  = S_SWR;
      end
      S_SWR: begin
        cmd.sym_wr     = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_status = htbd_pkg::STAT_OK;
        state_next     = S_RESP;
      end
      S_DNEXT: begin
        cmd.res_status = htbd_pkg::STAT_INVALID;
        if (st.slot_zero) begin
          cmd.dec_err = 1'b1;
          cmd.res_set = 1'b1;
          state_next  = S_RESP;
        end else begin
          cmd.dec_step = 1'b1;
          state_next   = S_DEVAL;
        end
      end
      S_DEVAL: begin
        cmd.res_set    = 1'b1;
        cmd.res_status = htbd_pkg::STAT_OK;
        if (st.leaf) begin
          cmd.dec_leaf  = 1'b1;
          cmd.res_valid = 1'b1;
        end else begin
          cmd.dec_down = 1'b1;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/htbd_dp.sv
// Datapath for the Huffman tree bit decoder: node store, root entry, counters,
// walk registers and the output register. Depends on htbd_pkg.
module htbd_dp #(
  parameter int NODE_COUNT   = 512,
  parameter int MAX_CODE_LEN = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [htbd_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [htbd_pkg::S_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [htbd_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [htbd_pkg::M_USER_W-1:0]  m_tuser,
  input  logic                           cfg_we,
  input  logic [htbd_pkg::BITS_W-1:0]    cfg_wdata,
  input  htbd_pkg::ctl_cmd_t             cmd,
  output htbd_pkg::ctl_stat_t            st
);

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int FREE_W  = IDX_W + 1;
  localparam int CNT_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int SYM_W   = htbd_pkg::SYM_W;
  localparam int ENTRY_W = 2 * IDX_W + SYM_W;

  // latched request
  logic [htbd_pkg::CMD_W-1:0]  in_cmd;
  logic [SYM_W-1:0]            in_sym;
  logic [htbd_pkg::LEN_W-1:0]  in_len;
  logic [htbd_pkg::CODE_W-1:0] in_code;
  logic                        in_bit;

  logic [htbd_pkg::BITS_W-1:0] total_bits;
  logic [htbd_pkg::BITS_W-1:0] bits_seen;
  logic                        dec_error;
  logic [IDX_W-1:0]            cur;
  logic [IDX_W-1:0]            nxt;
  logic [IDX_W-1:0]            node;
  logic [CNT_W-1:0]            cnt;
  logic [FREE_W-1:0]           free_cnt;

  logic [IDX_W-1:0]   root_l;
  logic [IDX_W-1:0]   root_r;
  logic [SYM_W-1:0]   root_s;

  logic [ENTRY_W-1:0] mem [NODE_COUNT];
  logic [ENTRY_W-1:0] mem_q;
  logic               rd_root;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [ENTRY_W-1:0] ent;
  logic [IDX_W-1:0]   ent_l;
  logic [IDX_W-1:0]   ent_r;
  logic [SYM_W-1:0]   ent_s;
  logic [CNT_W-1:0]   cnt_dec;
  logic               code_bit;
  logic               dir;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   free_idx;

  logic [SYM_W-1:0]            res_sym;
  logic                        res_valid;
  logic [htbd_pkg::STAT_W-1:0] res_status;
  logic [SYM_W-1:0]            out_sym;
  logic                        out_valid;
  logic [htbd_pkg::STAT_W-1:0] out_status;

  assign ent      = rd_root ? {root_l, root_r, root_s} : mem_q;
  assign ent_l    = ent[ENTRY_W-1 -: IDX_W];
  assign ent_r    = ent[SYM_W +: IDX_W];
  assign ent_s    = ent[SYM_W-1:0];
  assign cnt_dec  = cnt - 1'b1;
  assign code_bit = in_code[htbd_pkg::POS_W'(cnt_dec)];
  assign dir      = (in_cmd == htbd_pkg::CMD_DECODE) ? in_bit : code_bit;
  assign slot     = dir ? ent_r : ent_l;
  assign free_idx = free_cnt[IDX_W-1:0];

  assign st.cmd       = in_cmd;
  assign st.err       = dec_error;
  assign st.bits_done = (bits_seen >= total_bits);
  assign st.len_bad   = (in_len > htbd_pkg::LEN_W'(MAX_CODE_LEN));
  assign st.len_zero  = (in_len == '0);
  assign st.cnt_one   = (cnt == CNT_W'(1));
  assign st.slot_zero = (slot == '0);
  assign st.pool_full = (free_cnt >= FREE_W'(NODE_COUNT));
  assign st.leaf      = (ent_l == '0) && (ent_r == '0);
  assign st.cur_root  = (cur == '0);
  assign st.out_free  = !m_tvalid || m_tready;

  // read port
  always_comb begin
    rd_en   = cmd.rd_node || cmd.dec_start || cmd.dec_step;
    rd_addr = node;
    if (cmd.dec_start) begin
      rd_addr = cur;
    end else if (cmd.dec_step) begin
      rd_addr = slot;
    end
  end

  // write port; the root lives in registers and is never written here
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = ent;
    if (cmd.link && (node != '0)) begin
      wr_en   = 1'b1;
      wr_data = dir ? {ent_l, free_idx, ent_s} : {free_idx, ent_r, ent_s};
    end else if (cmd.alloc) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '0;
    end else if (cmd.sym_wr && (node != '0)) begin
      wr_en   = 1'b1;
      wr_data = {ent_l, ent_r, in_sym};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      rd_root <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_cmd  <= s_tuser;
      in_sym  <= s_tdata[7:0];
      in_len  <= s_tdata[14:8];
      in_code <= s_tdata[78:15];
      in_bit  <= s_tdata[79];
    end
    if (cmd.ld_start) begin
      node <= '0;
      cnt  <= in_len[CNT_W-1:0];
    end else if (cmd.follow) begin
      node <= slot;
      cnt  <= cnt_dec;
    end else if (cmd.alloc) begin
      node <= free_idx;
      cnt  <= cnt_dec;
    end
    if (cmd.dec_step) begin
      nxt <= slot;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_valid  <= cmd.res_valid;
      res_sym    <= cmd.res_valid ? ent_s : '0;
    end
    if (cmd.out_load) begin
      out_sym    <= res_sym;
      out_valid  <= res_valid;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= '0;
    end else if (cfg_we) begin
      total_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      root_l    <= '0;
      root_r    <= '0;
      root_s    <= '0;
      free_cnt  <= FREE_W'(1);
      cur       <= '0;
      bits_seen <= '0;
      dec_error <= 1'b0;
    end else begin
      if (cmd.link && (node == '0)) begin
        if (dir) begin
          root_r <= free_idx;
        end else begin
          root_l <= free_idx;
        end
      end
      if (cmd.sym_wr && (node == '0)) begin
        root_s <= in_sym;
      end
      if (cmd.alloc) begin
        free_cnt <= free_cnt + 1'b1;
      end
      if (cmd.dec_start) begin
        bits_seen <= bits_seen + 1'b1;
      end
      if (cmd.dec_err) begin
        dec_error <= 1'b1;
      end
      if (cmd.dec_leaf) begin
        cur <= '0;
      end else if (cmd.dec_down) begin
        cur <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, out_status, out_sym};
  assign m_tuser = out_valid;

endmodule

FILE: sv/huffman_tree_bit_decoder.sv
// Huffman tree bit decoder top level: controller plus datapath.
// Depends on htbd_pkg, htbd_ctrl and htbd_dp.
//
// One request is handled at a time; s_tready is high only while the block is
// idle, and a result waits in the output register while the next request is
// taken. A decoded bit reads the current node and then the child it points
// to, both through the registered read port of the node store; a bit that
// finds no child stops after the first read. A load reads one node per code
// bit, then follows an existing branch or links and allocates a new node,
// and at the end reads the last node to write its symbol; a load that runs
// out of nodes stops at the bit that fails. A stalled output holds the block
// until the result is taken. The root entry is held in registers, so clear
// needs no clearing pass of the store.
module huffman_tree_bit_decoder #(
  parameter int NODE_COUNT   = 512,
  parameter int MAX_CODE_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // symbol[7:0], code_len[14:8], code_bits[78:15], bit_req[79]
  input  logic [htbd_pkg::S_DATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [htbd_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // symbol_out[7:0], status[10:8], zero[15:11]
  output logic [htbd_pkg::M_DATA_W-1:0] m_tdata,
  // symbol_valid[0]
  output logic [htbd_pkg::M_USER_W-1:0] m_tuser,
  input  logic                          cfg_we,
  input  logic [htbd_pkg::BITS_W-1:0]   cfg_wdata
);

  htbd_pkg::ctl_cmd_t  cmd;
  htbd_pkg::ctl_stat_t st;

  htbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  htbd_dp #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for huffman_tree_bit_decoder: loads random prefix codes,
// streams their bits plus noise requests, and checks every result against a tree model.
// Depends on htbd_pkg and the huffman_tree_bit_decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES   = 512;
  localparam int MAX_LEN = 64;

  typedef struct packed {
    logic [htbd_pkg::SYM_W-1:0]  symbol;
    logic                        valid;
    logic [htbd_pkg::STAT_W-1:0] status;
  } decoded_t;

  class tree_decoder_model;
    int unsigned                 left_child[NODES];
    int unsigned                 right_child[NODES];
    logic [htbd_pkg::SYM_W-1:0]  node_symbol[NODES];
    int unsigned                 free_node;
    int unsigned                 cur_node;
    logic [htbd_pkg::BITS_W-1:0] bits_seen;
    logic [htbd_pkg::BITS_W-1:0] total_bits;
    bit                          stuck;
    decoded_t                    expected_results[$];
    int                          errors;

    function new();
      clear_tree();
      total_bits = '0;
      errors = 0;
    endfunction

    function void clear_tree();
      foreach (left_child[i]) begin
        left_child[i] = 0;
        right_child[i] = 0;
        node_symbol[i] = '0;
      end
      free_node = 1;
      cur_node = 0;
      bits_seen = '0;
      stuck = 0;
    endfunction

    function logic [htbd_pkg::STAT_W-1:0] load_code(logic [htbd_pkg::SYM_W-1:0] sym,
                                                    logic [htbd_pkg::LEN_W-1:0] len,
                                                    logic [htbd_pkg::CODE_W-1:0] code);
      int unsigned node;
      int unsigned nxt;
      int i;
      node = 0;
      if (len > MAX_LEN) return htbd_pkg::STAT_INVALID;
      for (i = len; i > 0; i--) begin
        nxt = code[i-1] ? right_child[node] : left_child[node];
        if (nxt == 0) begin
          if (free_node >= NODES) return htbd_pkg::STAT_FULL;
          left_child[free_node] = 0;
          right_child[free_node] = 0;
          node_symbol[free_node] = '0;
          if (code[i-1]) right_child[node] = free_node;
          else left_child[node] = free_node;
          nxt = free_node;
          free_node++;
        end
        node = nxt;
      end
      node_symbol[node] = sym;
      return htbd_pkg::STAT_OK;
    endfunction

    // note an accepted request; returns the status it should produce
    function logic [htbd_pkg::STAT_W-1:0] note_request(logic [htbd_pkg::CMD_W-1:0] cmd,
                                                       logic [htbd_pkg::SYM_W-1:0] sym,
                                                       logic [htbd_pkg::LEN_W-1:0] len,
                                                       logic [htbd_pkg::CODE_W-1:0] code,
                                                       logic bit_val);
      decoded_t res;
      int unsigned nxt;
      res = '0;
      res.status = htbd_pkg::STAT_OK;
      case (cmd)
        htbd_pkg::CMD_CLEAR: clear_tree();
        htbd_pkg::CMD_LOAD: res.status = load_code(sym, len, code);
        htbd_pkg::CMD_DECODE: begin
          if (stuck) res.status = htbd_pkg::STAT_INVALID;
          else if (bits_seen >= total_bits) res.status = htbd_pkg::STAT_IGNORED;
          else begin
            bits_seen = bits_seen + 1'b1;
            nxt = bit_val ? right_child[cur_node] : left_child[cur_node];
            if (nxt == 0) begin
              stuck = 1;
              res.status = htbd_pkg::STAT_INVALID;
            end else if (left_child[nxt] == 0 && right_child[nxt] == 0) begin
              res.symbol = node_symbol[nxt];
              res.valid = 1'b1;
              cur_node = 0;
            end else begin
              cur_node = nxt;
            end
          end
        end
        default: begin
          if (stuck) res.status = htbd_pkg::STAT_INVALID;
          else if (bits_seen < total_bits) res.status = htbd_pkg::STAT_SHORT;
          else if (cur_node != 0) res.status = htbd_pkg::STAT_INCOMPLETE;
        end
      endcase
      expected_results = {expected_results, res};
      return res.status;
    endfunction

    function void check_result(logic [htbd_pkg::M_DATA_W-1:0] data,
                               logic [htbd_pkg::M_USER_W-1:0] user);
      decoded_t exp_res;
      if (expected_results.size() == 0) begin
        $error("unexpected result: symbol_out %0d status %0d symbol_valid %0d",
               data[7:0], data[10:8], user[0]);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (data[7:0] !== exp_res.symbol) begin
        $error("symbol_out: expected %0d, got %0d", exp_res.symbol, data[7:0]);
        errors++;
      end
      if (data[10:8] !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, data[10:8]);
        errors++;
      end
      if (user[0] !== exp_res.valid) begin
        $error("symbol_valid: expected %0d, got %0d", exp_res.valid, user[0]);
        errors++;
      end
      if (data[15:11] !== 5'd0) begin
        $error("zero: expected 0, got %0d", data[15:11]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [htbd_pkg::S_DATA_W-1:0]   s_tdata = '0;
  logic [htbd_pkg::S_USER_W-1:0]   s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [htbd_pkg::M_DATA_W-1:0]   m_tdata;
  logic [htbd_pkg::M_USER_W-1:0]   m_tuser;
  logic                            cfg_we = 1'b0;
  logic [htbd_pkg::BITS_W-1:0]     cfg_wdata = '0;

  tree_decoder_model decoder;
  int send_idle_pct = 22;
  int recv_idle_pct = 71;
  int sent_count = 0;

  huffman_tree_bit_decoder #(
    .NODE_COUNT(NODES),
    .MAX_CODE_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) decoder.check_result(m_tdata, m_tuser);
  end

  task automatic send_request(input logic [htbd_pkg::CMD_W-1:0] cmd,
                              input logic [htbd_pkg::SYM_W-1:0] sym,
                              input logic [htbd_pkg::LEN_W-1:0] len,
                              input logic [htbd_pkg::CODE_W-1:0] code,
                              input logic bit_val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {bit_val, code, len, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    void'(decoder.note_request(cmd, sym, len, code, bit_val));
    sent_count++;
  endtask

  function automatic logic [htbd_pkg::CODE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_decode(input logic bit_val);
    send_request(htbd_pkg::CMD_DECODE, 8'($urandom), 7'($urandom), rand64(), bit_val);
  endtask

  task automatic send_plain(input logic [htbd_pkg::CMD_W-1:0] cmd);
    send_request(cmd, 8'($urandom), 7'($urandom), rand64(), 1'($urandom));
  endtask

  // hold requests off until every outstanding result has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    while (decoder.pending() != 0) @(posedge clk);
  endtask

  task automatic write_total_bits(input logic [htbd_pkg::BITS_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    decoder.total_bits = value;
    cfg_we <= 1'b0;
  endtask

  // clear, load a random prefix code (sometimes missing a leaf), decode codewords, finish
  task automatic run_code_sequence();
    logic [htbd_pkg::CODE_W-1:0] codes[$];
    int                          lens[$];
    logic [htbd_pkg::CODE_W-1:0] c;
    int                          l, k, j, b, drop, words;
    codes = {64'd0};
    lens = {0};
    send_plain(htbd_pkg::CMD_CLEAR);
    repeat ($urandom_range(1, 9)) begin
      k = $urandom_range(codes.size() - 1);
      if (lens[k] < 10) begin
        c = codes[k];
        l = lens[k];
        codes.delete(k);
        lens.delete(k);
        codes = {codes, c << 1};
        lens = {lens, l + 1};
        codes = {codes, (c << 1) | 64'd1};
        lens = {lens, l + 1};
      end
    end
    drop = ($urandom_range(99) < 20) ? $urandom_range(codes.size() - 1) : -1;
    for (j = 0; j < codes.size(); j++) begin
      if (j != drop)
        send_request(htbd_pkg::CMD_LOAD, 8'($urandom), 7'(lens[j]),
                     (rand64() << lens[j]) | codes[j], 1'($urandom));
    end
    words = $urandom_range(1, 8);
    repeat (words) begin
      j = $urandom_range(codes.size() - 1);
      for (b = lens[j] - 1; b >= 0; b--) send_decode(codes[j][b]);
      if ($urandom_range(99) < 10) send_decode(1'($urandom));
    end
    send_plain(htbd_pkg::CMD_FINISH);
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_request(htbd_pkg::CMD_LOAD, 8'($urandom), 7'($urandom_range(127)), rand64(),
                      1'($urandom));
      1: send_decode(1'($urandom));
      2: send_plain(htbd_pkg::CMD_FINISH);
      default: send_plain(htbd_pkg::CMD_CLEAR);
    endcase
  endtask

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [htbd_pkg::BITS_W-1:0] total;
    int phase, target;
    decoder = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tree, sticky error, short/incomplete/ignored, repeats, pool full
    send_plain(htbd_pkg::CMD_FINISH);
    send_decode(1'b0);
    write_total_bits(48'd20);
    send_decode(1'b1);
    send_decode(1'b0);
    send_plain(htbd_pkg::CMD_FINISH);
    send_plain(htbd_pkg::CMD_CLEAR);
    send_request(htbd_pkg::CMD_LOAD, 8'hFF, 7'd0, rand64(), 1'b0);
    send_request(htbd_pkg::CMD_LOAD, 8'h11, 7'd65, rand64(), 1'b1);
    send_request(htbd_pkg::CMD_LOAD, 8'h22, 7'd127, '1, 1'b1);
    send_request(htbd_pkg::CMD_LOAD, 8'h00, 7'd1, ~64'd1, 1'b0);
    send_request(htbd_pkg::CMD_LOAD, 8'hA5, 7'd2, 64'd2, 1'b0);
    send_request(htbd_pkg::CMD_LOAD, 8'h5A, 7'd2, 64'd3, 1'b0);
    send_decode(1'b1);
    send_request(htbd_pkg::CMD_LOAD, 8'h3C, 7'd2, 64'd3, 1'b1);
    send_decode(1'b1);
    send_decode(1'b0);
    send_plain(htbd_pkg::CMD_FINISH);
    write_total_bits(48'd4);
    send_decode(1'b1);
    send_plain(htbd_pkg::CMD_FINISH);
    send_decode(1'b0);
    write_total_bits('1);
    send_plain(htbd_pkg::CMD_CLEAR);
    send_request(htbd_pkg::CMD_LOAD, 8'h01, 7'd64, '1, 1'b0);
    send_request(htbd_pkg::CMD_LOAD, 8'h02, 7'd64, '0, 1'b1);
    repeat (7) send_request(htbd_pkg::CMD_LOAD, 8'($urandom), 7'd64, rand64(), 1'($urandom));
    send_decode(1'b1);
    send_decode(1'b0);

    // random phases; every phase boundary waits for all results
    sent_count = 0;
    target = 0;
    for (phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 71;
      end else if (phase < 6) begin
        send_idle_pct = 71;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: total = 48'($urandom_range(8, 40));
        1: total = {16'($urandom), $urandom};
        2: total = '1;
        default: total = 48'd1;
      endcase
      write_total_bits(total);
      target += 40;
      while (sent_count < target) begin
        if ($urandom_range(99) < 15) send_noise();
        else run_code_sequence();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (decoder.errors == 0 && decoder.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

FILE: huffman_tree_bit_decoder.f
sv/htbd_pkg.sv
sv/htbd_ctrl.sv
sv/htbd_dp.sv
sv/huffman_tree_bit_decoder.sv
tb/testbench.sv
